// ===== rtl/bfit_pkg.sv =====
// ----------------------------------------------------------------------------
// bfit_pkg : shared types and helpers for the block face index transform
// Item structs, register indexes and small combinational helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfit_pkg;

  localparam int MAX_NODES = 1024;

  localparam int CNT_W  = 11;  // node count width
  localparam int IDX_W  = 10;  // node index width
  localparam int SIDE_W = 3;
  localparam int ORI_W  = 9;
  localparam int CFG_IDX_W = 3;

  // Face codes
  localparam logic [SIDE_W-1:0] SIDE_KMAX = 3'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOST_NODES_I  = 3'd0,
    REG_HOST_NODES_J  = 3'd1,
    REG_HOST_NODES_K  = 3'd2,
    REG_DONOR_NODES_I = 3'd3,
    REG_DONOR_NODES_J = 3'd4,
    REG_DONOR_NODES_K = 3'd5,
    REG_HOST_SIDE     = 3'd6,
    REG_ORIENTATION   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] host_i;
    logic [IDX_W-1:0] host_j;
    logic [IDX_W-1:0] host_k;
    logic [1:0]       axis;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  donor_i;
    logic [IDX_W-1:0]  donor_j;
    logic [IDX_W-1:0]  donor_k;
    logic [SIDE_W-1:0] donor_side;
    logic              on_patch;
    logic              out_of_range;
    logic              bad_orientation;
  } out_item_t;

  // Clamp a node count into 2..MAX_NODES
  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] res;
    res = n;
    if (n < CNT_W'(2))
      res = CNT_W'(2);
    else if ({1'b0, n} > (CNT_W+1)'(MAX_NODES))
      res = CNT_W'(MAX_NODES);
    return res;
  endfunction

  // Target axis of an orientation digit (digit mod 3)
  function automatic logic [1:0] dig_axis(input logic [2:0] dig);
    logic [1:0] res;
    case (dig)
      3'd0:    res = 2'd0;
      3'd1:    res = 2'd1;
      3'd2:    res = 2'd2;
      3'd3:    res = 2'd0;
      3'd4:    res = 2'd1;
      3'd5:    res = 2'd2;
      3'd6:    res = 2'd0;
      3'd7:    res = 2'd1;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/block_face_index_transform.sv =====
// ----------------------------------------------------------------------------
// block_face_index_transform : host-to-donor node index mapping
// Maps host grid nodes across one block face onto the donor block through a
// signed permutation, flags patch membership, range and orientation errors.
// ----------------------------------------------------------------------------
// Takes one item per clock while busy is low and returns its result on
// out_item with out_valid high for a single cycle; it passes through the
// four register stages of the pipeline and nothing else holds an item up.
// busy is high only during reset and the cycle after it. Results cannot be
// held off, so none are buffered. Configuration (host/donor node counts,
// host face, orientation code) is taken on cfg_valid, always ready, and must
// only be written while no item is in flight; the face extent, donor face,
// permutation and donor low corner are re-derived from it every cycle.
`timescale 1ns / 1ps
`default_nettype none

module block_face_index_transform (
  input  wire                               clk,
  input  wire                               rst_n,
  // item input
  input  wire                               start,
  output logic                              busy,
  input  wire bfit_pkg::in_item_t           in_item,
  // result output
  output logic                              out_valid,
  output bfit_pkg::out_item_t               out_item,
  // configuration write
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [bfit_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bfit_pkg::CNT_W-1:0]         cfg_data
);

  import bfit_pkg::*;

  localparam int U_W = IDX_W + 2;   // h - lo, signed
  localparam int D_W = IDX_W + 4;   // dlo + up to three terms, signed

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  host_n_r  [3];
  logic [CNT_W-1:0]  donor_n_r [3];
  logic [SIDE_W-1:0] host_side_r;
  logic [ORI_W-1:0]  orient_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        host_n_r[c]  <= CNT_W'(2);
        donor_n_r[c] <= CNT_W'(2);
      end
      host_side_r <= '0;
      orient_r    <= ORI_W'(136);   // identity: digits 0,1,2
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOST_NODES_I:  host_n_r[0]  <= cfg_data;
        REG_HOST_NODES_J:  host_n_r[1]  <= cfg_data;
        REG_HOST_NODES_K:  host_n_r[2]  <= cfg_data;
        REG_DONOR_NODES_I: donor_n_r[0] <= cfg_data;
        REG_DONOR_NODES_J: donor_n_r[1] <= cfg_data;
        REG_DONOR_NODES_K: donor_n_r[2] <= cfg_data;
        REG_HOST_SIDE:     host_side_r  <= cfg_data[SIDE_W-1:0];
        REG_ORIENTATION:   orient_r     <= cfg_data[ORI_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Derived face geometry, refreshed every cycle from the registers. Only
  // read from stage 2 onwards, so a write is visible to the next item.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  hn_nxt [3], hn_r [3];
  logic [CNT_W-1:0]  dn_nxt [3], dn_r [3];
  logic [1:0]        dir_nxt, dir_r;          // host face normal axis
  logic [IDX_W-1:0]  lo_dir_nxt, lo_dir_r;    // host index on that face
  logic [1:0]        tgt_nxt [3], tgt_r [3];  // donor row of each column
  logic              neg_nxt [3], neg_r [3];  // column sign
  logic [SIDE_W-1:0] dside_nxt, dside_r;
  logic [IDX_W-1:0]  dlo_nxt [3], dlo_r [3];
  logic              bad_nxt, bad_r;

  always_comb begin
    logic [SIDE_W-1:0] side;
    logic              odd;
    logic [2:0]        dig [3];
    logic [1:0]        n_pos, n_neg;
    logic [CNT_W-1:0]  dn_m1;

    side = (host_side_r > SIDE_KMAX) ? SIDE_KMAX : host_side_r;
    odd  = side[0];
    dir_nxt = side[2:1];
    bad_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      hn_nxt[c]  = sat_count(host_n_r[c]);
      dn_nxt[c]  = sat_count(donor_n_r[c]);
      dig[c]     = orient_r[3*c +: 3];
      tgt_nxt[c] = dig_axis(dig[c]);
      neg_nxt[c] = (dig[c] > 3'd2);
      if (dig[c] > 3'd5)
        bad_nxt = 1'b1;
    end
    lo_dir_nxt = odd ? IDX_W'(hn_nxt[dir_nxt] - CNT_W'(1)) : '0;

    // donor face: axis from the normal digit, min/max flips with its sign
    dside_nxt = {tgt_nxt[dir_nxt], odd ^ ~neg_nxt[dir_nxt]};

    for (int r = 0; r < 3; r++) begin
      n_pos = '0;
      n_neg = '0;
      for (int c = 0; c < 3; c++) begin
        if (tgt_nxt[c] == 2'(r)) begin
          if (neg_nxt[c]) n_neg = n_neg + 2'd1;
          else            n_pos = n_pos + 2'd1;
        end
      end
      dn_m1 = dn_nxt[r] - CNT_W'(1);
      if (dside_nxt[2:1] == 2'(r))
        dlo_nxt[r] = dside_nxt[0] ? dn_m1[IDX_W-1:0] : '0;
      else
        dlo_nxt[r] = (n_neg > n_pos) ? dn_m1[IDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    hn_r     <= hn_nxt;
    dn_r     <= dn_nxt;
    dir_r    <= dir_nxt;
    lo_dir_r <= lo_dir_nxt;
    tgt_r    <= tgt_nxt;
    neg_r    <= neg_nxt;
    dside_r  <= dside_nxt;
    dlo_r    <= dlo_nxt;
    bad_r    <= bad_nxt;
  end

  // --------------------------------------------------------------------------
  // Handshake: nothing stalls the pipe, busy only covers reset
  // --------------------------------------------------------------------------
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // --------------------------------------------------------------------------
  // Stage 1: capture the item
  // --------------------------------------------------------------------------
  logic             v1_r;
  logic [IDX_W-1:0] h1_r [3];
  logic [1:0]       axis1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= accept;
  end

  always_ff @(posedge clk) begin
    h1_r[0] <= in_item.host_i;
    h1_r[1] <= in_item.host_j;
    h1_r[2] <= in_item.host_k;
    axis1_r <= in_item.axis;
  end

  // --------------------------------------------------------------------------
  // Stage 2: offsets from the host low corner, patch membership
  // --------------------------------------------------------------------------
  logic                  v2_r;
  logic signed [U_W-1:0] u_nxt [3], u2_r [3];
  logic                  onp_nxt, onp2_r;

  always_comb begin
    logic [IDX_W-1:0] lo;
    logic             inside_face;

    inside_face = 1'b1;
    for (int c = 0; c < 3; c++) begin
      lo = (dir_r == 2'(c)) ? lo_dir_r : '0;
      u_nxt[c] = $signed({2'b00, h1_r[c]}) - $signed({2'b00, lo});
      // off the normal axis the face spans the whole block
      if (dir_r != 2'(c) && ({1'b0, h1_r[c]} >= hn_r[c]))
        inside_face = 1'b0;
    end
    onp_nxt = (axis1_r == dir_r) && (h1_r[dir_r] == lo_dir_r) && inside_face;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    u2_r   <= u_nxt;
    onp2_r <= onp_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: signed permutation plus donor low corner
  // --------------------------------------------------------------------------
  logic                  v3_r;
  logic signed [D_W-1:0] d_nxt [3], d3_r [3];
  logic                  onp3_r;

  always_comb begin
    logic signed [D_W-1:0] term;
    for (int r = 0; r < 3; r++) begin
      d_nxt[r] = $signed({{(D_W-IDX_W){1'b0}}, dlo_r[r]});
      for (int c = 0; c < 3; c++) begin
        term = D_W'(u2_r[c]);
        if (tgt_r[c] == 2'(r))
          d_nxt[r] = neg_r[c] ? d_nxt[r] - term : d_nxt[r] + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    d3_r   <= d_nxt;
    onp3_r <= onp2_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: donor range check, output register
  // --------------------------------------------------------------------------
  logic      v4_r;
  out_item_t out_nxt, out_r;

  always_comb begin
    logic oor;
    oor = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (d3_r[r] < 0 || d3_r[r] >= $signed({{(D_W-CNT_W){1'b0}}, dn_r[r]}))
        oor = 1'b1;
    end
    out_nxt.donor_i         = oor ? '0 : d3_r[0][IDX_W-1:0];
    out_nxt.donor_j         = oor ? '0 : d3_r[1][IDX_W-1:0];
    out_nxt.donor_k         = oor ? '0 : d3_r[2][IDX_W-1:0];
    out_nxt.donor_side      = dside_r;
    out_nxt.on_patch        = onp3_r;
    out_nxt.out_of_range    = oor;
    out_nxt.bad_orientation = bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = v4_r;
  assign out_item  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("item accepted without a result four cycles later");

  a_oor_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_of_range) |->
      (out_item.donor_i == '0 && out_item.donor_j == '0 && out_item.donor_k == '0))
    else $error("out-of-range result carries a nonzero donor index");

  a_dside : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.donor_side <= SIDE_KMAX))
    else $error("donor face code above kmax");

  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

`default_nettype wire
